// ===== rtl/repulsive_lj_pair_force_accumulator_macros.svh =====
// Assertion macros used by the checker file of the pair force accumulator.
`ifndef REPULSIVE_LJ_PAIR_FORCE_ACCUMULATOR_MACROS_SVH
`define REPULSIVE_LJ_PAIR_FORCE_ACCUMULATOR_MACROS_SVH

// Property checked on every clock edge outside reset.
`define RLJPFA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rljpfa: property failed");

// Property checked on every clock edge, reset included.
`define RLJPFA_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("rljpfa: property failed");

`endif

// ===== rtl/rljpfa_pkg.sv =====
// Package of the pair force accumulator: widths, constants and word types.
package rljpfa_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int COORD_BITS  = 32;
	localparam int ACC_BITS    = 48;
	localparam int BOX_W       = 31;
	localparam int CUT_W       = 24;
	localparam int DIAM_W      = 24;
	localparam int DSUM_W      = DIAM_W + 1;
	localparam int DSQ_W       = 2 * DSUM_W;
	localparam int MAG_W       = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_BOX_X  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 2'd2;

	localparam logic [BOX_W-1:0] BOX_RESET    = 31'd655360;
	localparam logic [CUT_W-1:0] CUTOFF_RESET = 24'd82570;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] own_x;
		logic signed [COORD_BITS-1:0] own_y;
		logic signed [COORD_BITS-1:0] own_z;
		logic signed [COORD_BITS-1:0] partner_x;
		logic signed [COORD_BITS-1:0] partner_y;
		logic signed [COORD_BITS-1:0] partner_z;
		logic [DIAM_W-1:0]            own_diameter;
		logic [DIAM_W-1:0]            partner_diameter;
		logic                         last_pair;
	} in_item_t;

	typedef struct packed {
		logic signed [ACC_BITS-1:0] force_x;
		logic signed [ACC_BITS-1:0] force_y;
		logic signed [ACC_BITS-1:0] force_z;
		logic                       overflow;
	} out_item_t;

	// Classified pair as it travels from the front to the back.
	typedef struct packed {
		logic [MAG_W-1:0]  mag_x;
		logic [MAG_W-1:0]  mag_y;
		logic [MAG_W-1:0]  mag_z;
		logic              neg_x;
		logic              neg_y;
		logic              neg_z;
		logic              far;
		logic [DSUM_W-1:0] dsum;
		logic              last;
	} pair_t;

endpackage

// ===== rtl/repulsive_lj_pair_force_accumulator.sv =====
// Top level of the repulsive Lennard-Jones pair force accumulator.
//
// The block takes one particle pair per input word, forms the minimum-image
// separation in x and y (z is not wrapped), and when the pair lies inside the
// cutoff adds its repulsive Lennard-Jones force to a running sum; on a word
// flagged last_pair it sends the summed force and the sticky overflow flag as
// one output word and clears both. A one-stage front accepts a word in every
// cycle while the queue has room; the back works on one pair at a time, and its
// pace is set by one shared 64-bit multiplier (four 32 by 32 partial products)
// and one divider that yields a quotient bit a cycle. A pair that is far away
// goes straight to the end, one outside the cutoff stops after the cutoff test,
// and one inside the cutoff takes the longest, since it needs four divisions and
// eleven products. The output word sits in its own register, so the back goes on
// with the next pair while a finished sum waits to be taken.
// Configuration writes are accepted in every cycle and are meant to be made while
// the block is idle.
module repulsive_lj_pair_force_accumulator
	import rljpfa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [BOX_W-1:0] box_x_q, box_y_q;
	logic [CUT_W-1:0] cutoff_q;

	logic  push_valid, push_ready, pop_valid, pop_ready;
	pair_t push_data, pop_data;

	// Registers are always writable; an index beyond the list is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q  <= BOX_RESET;
			box_y_q  <= BOX_RESET;
			cutoff_q <= CUTOFF_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BOX_X:  box_x_q  <= cfg_data[BOX_W-1:0];
				CFG_BOX_Y:  box_y_q  <= cfg_data[BOX_W-1:0];
				CFG_CUTOFF: cutoff_q <= cfg_data[CUT_W-1:0];
				default:    ;
			endcase
		end
	end

	// The front wraps and classifies each pair.
	rljpfa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.box_x      (box_x_q),
		.box_y      (box_y_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// The queue lets the front keep taking words while the back is busy.
	rljpfa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// The back computes the force, accumulates and emits the sum.
	rljpfa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.cutoff    (cutoff_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/rljpfa_front.sv =====
// Front end: takes pairs, forms the wrapped separation and classifies it.
module rljpfa_front
	import rljpfa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	input  logic [BOX_W-1:0] box_x,
	input  logic [BOX_W-1:0] box_y,
	output logic             push_valid,
	input  logic             push_ready,
	output pair_t            push_data
);

	localparam int DW = COORD_BITS + 1;
	localparam int WW = COORD_BITS + 3;

	logic                 valid_s1;
	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;
	logic [DSUM_W-1:0]    dsum_s1;
	logic                 last_s1;
	logic signed [WW-1:0] wx, wy, wz;
	logic [WW-1:0]        ax, ay, az;

	// Minimum image: pull the component back by one box length at most each way.
	function automatic logic signed [WW-1:0] wrap(input logic signed [DW-1:0] c,
		input logic [BOX_W-1:0] len);
		logic signed [WW:0] v;
		logic signed [WW:0] l;
		v = (WW+1)'(c);
		l = $signed({{(WW+1-BOX_W){1'b0}}, len});
		if ((v <<< 1) > l) begin
			v = v - l;
		end
		if ((v <<< 1) < -l) begin
			v = v + l;
		end
		return v[WW-1:0];
	endfunction

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dx_s1   <= DW'(in_data.own_x) - DW'(in_data.partner_x);
			dy_s1   <= DW'(in_data.own_y) - DW'(in_data.partner_y);
			dz_s1   <= DW'(in_data.own_z) - DW'(in_data.partner_z);
			dsum_s1 <= DSUM_W'(in_data.own_diameter) + DSUM_W'(in_data.partner_diameter);
			last_s1 <= in_data.last_pair;
		end
	end

	always_comb begin
		wx = wrap(dx_s1, box_x);
		wy = wrap(dy_s1, box_y);
		wz = WW'(dz_s1);
		ax = wx[WW-1] ? $unsigned(-wx) : $unsigned(wx);
		ay = wy[WW-1] ? $unsigned(-wy) : $unsigned(wy);
		az = wz[WW-1] ? $unsigned(-wz) : $unsigned(wz);
		push_data.mag_x = ax[MAG_W-1:0];
		push_data.mag_y = ay[MAG_W-1:0];
		push_data.mag_z = az[MAG_W-1:0];
		push_data.neg_x = wx[WW-1];
		push_data.neg_y = wy[WW-1];
		push_data.neg_z = wz[WW-1];
		push_data.far   = |{ax[WW-1:MAG_W], ay[WW-1:MAG_W], az[WW-1:MAG_W]};
		push_data.dsum  = dsum_s1;
		push_data.last  = last_s1;
	end

endmodule

// ===== rtl/rljpfa_queue.sv =====
// Short queue of classified pairs between the front and the back.
module rljpfa_queue
	import rljpfa_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  pair_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output pair_t pop_data
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	pair_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  count_q;
	logic           do_push, do_pop;

	assign push_ready = (count_q != CW'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/rljpfa_mul.sv =====
// Shared 64 by 64 multiplier built from four 32 by 32 partial products.
module rljpfa_mul
	import rljpfa_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] p
);

	localparam int PARTS = 4;

	logic [2:0]   cnt_q;
	logic         busy_q, done_q;
	logic [1:0]   pk_q;
	logic [63:0]  pp_q, pp_next;
	logic [31:0]  ah, bh;
	logic [127:0] acc_q, pp_shift;

	assign done = done_q;
	assign p    = acc_q;

	always_comb begin
		ah      = cnt_q[0] ? a[63:32] : a[31:0];
		bh      = cnt_q[1] ? b[63:32] : b[31:0];
		pp_next = 64'(ah) * 64'(bh);
		case (pk_q)
			2'd0:    pp_shift = 128'(pp_q);
			2'd3:    pp_shift = 128'(pp_q) << 64;
			default: pp_shift = 128'(pp_q) << 32;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 3'(PARTS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != 3'(PARTS)) begin
				pp_q <= pp_next;
				pk_q <= cnt_q[1:0];
			end
			if (cnt_q != '0) begin
				acc_q <= acc_q + pp_shift;
			end
		end
	end

endmodule

// ===== rtl/rljpfa_div.sv =====
// Restoring divider, one quotient bit a cycle, saturating to all ones.
module rljpfa_div
	import rljpfa_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] n,
	input  logic [63:0]  d,
	output logic         done,
	output logic [63:0]  q,
	output logic         sat
);

	localparam int STEPS = 64;
	localparam int CW    = $clog2(STEPS + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q, sat_q;
	logic [63:0]   rem_q, quo_q, shifted;
	logic          ge;

	assign done = done_q;
	assign q    = quo_q;
	assign sat  = sat_q;

	always_comb begin
		shifted = {rem_q[62:0], quo_q[63]};
		ge      = rem_q[63] || (shifted >= d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (n[127:64] >= d) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CW'(STEPS);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (n[127:64] >= d) begin
				sat_q <= 1'b1;
				quo_q <= '1;
			end else begin
				sat_q <= 1'b0;
				rem_q <= n[127:64];
				quo_q <= n[63:0];
			end
		end else if (busy_q) begin
			rem_q <= ge ? shifted - d : shifted;
			quo_q <= {quo_q[62:0], ge};
		end
	end

endmodule

// ===== rtl/rljpfa_back.sv =====
// Back end: sequences the force of one pair over the shared units and accumulates.
module rljpfa_back
	import rljpfa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  pair_t            pop_data,
	input  logic [CUT_W-1:0] cutoff,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data
);

	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001,
		ST_SQ   = 12'b000000000010,
		ST_DSQ  = 12'b000000000100,
		ST_RHS  = 12'b000000001000,
		ST_DIVS = 12'b000000010000,
		ST_Q1   = 12'b000000100000,
		ST_Q2   = 12'b000001000000,
		ST_M    = 12'b000010000000,
		ST_DIVU = 12'b000100000000,
		ST_VMUL = 12'b001000000000,
		ST_ACC  = 12'b010000000000,
		ST_DONE = 12'b100000000000
	} state_t;

	localparam logic [63:0] ONE_Q32 = 64'd1 << 32;
	localparam logic [63:0] LIM_POS = (64'd1 << (ACC_BITS - 1)) - 64'd1;
	localparam logic [63:0] LIM_NEG = 64'd1 << (ACC_BITS - 1);

	state_t                     state_q;
	pair_t                      cur_q;
	logic [1:0]                 idx_q;
	logic [65:0]                r2_q, r2_next;
	logic [DSQ_W-1:0]           dsq_q;
	logic [63:0]                s_q, m_q;
	logic                       attract_q, sat_q, seen_q;
	logic signed [ACC_BITS-1:0] term_q;
	logic signed [ACC_BITS-1:0] sum_q [3];
	logic                       mul_start_q, div_start_q;
	logic [63:0]                mul_a_q, mul_b_q;
	logic [127:0]               div_n_q;
	logic                       out_valid_q;
	out_item_t                  out_q;

	logic                       mul_done, div_done, div_sat;
	logic [127:0]               mul_p, lhs;
	logic [63:0]                div_q;
	logic [63:0]                mq_val, twoq, t_val, u24, v_val, lim;
	logic                       mq_sat, twoq_sat, attract, term_sat, negative, acc_sat;
	logic [68:0]                u24_w;
	logic [MAG_W-1:0]           mag_next;
	logic                       neg_cur;
	logic signed [ACC_BITS-1:0] term_val, acc_val, acc_cur;
	logic signed [ACC_BITS:0]   acc_w;
	logic                       seen_all;
	logic                       emit;

	rljpfa_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.p      (mul_p)
	);

	rljpfa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.n      (div_n_q),
		.d      (r2_q[63:0]),
		.done   (div_done),
		.q      (div_q),
		.sat    (div_sat)
	);

	assign pop_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign seen_all  = seen_q | sat_q;
	assign emit      = (state_q == ST_DONE) && cur_q.last && (!out_valid_q || out_ready);

	always_comb begin
		r2_next = r2_q + {2'b00, mul_p[63:0]};
		lhs     = 128'(r2_q[63:0]) << (FRAC_BITS + 2);

		// Q32.32 product with saturation.
		mq_sat = |mul_p[127:96];
		mq_val = mq_sat ? '1 : mul_p[95:32];

		twoq_sat = mq_val[63];
		twoq     = twoq_sat ? '1 : {mq_val[62:0], 1'b0};
		attract  = (twoq < ONE_Q32);
		t_val    = attract ? ONE_Q32 - twoq : twoq - ONE_Q32;

		u24_w = (69'(div_q) << 4) + (69'(div_q) << 3);
		u24   = (|u24_w[68:64]) ? '1 : u24_w[63:0];

		case (idx_q)
			2'd0:    mag_next = cur_q.mag_y;
			default: mag_next = cur_q.mag_z;
		endcase
		case (idx_q)
			2'd0:    neg_cur = cur_q.neg_x;
			2'd1:    neg_cur = cur_q.neg_y;
			default: neg_cur = cur_q.neg_z;
		endcase

		negative = neg_cur != attract_q;
		lim      = negative ? LIM_NEG : LIM_POS;
		v_val    = mq_val;
		term_sat = v_val > lim;
		if (term_sat) begin
			v_val = lim;
		end
		term_val = negative ? -$signed(v_val[ACC_BITS-1:0]) : $signed(v_val[ACC_BITS-1:0]);

		acc_cur = sum_q[idx_q];
		acc_w   = (ACC_BITS+1)'(acc_cur) + (ACC_BITS+1)'(term_q);
		acc_sat = acc_w[ACC_BITS] != acc_w[ACC_BITS-1];
		if (acc_sat) begin
			acc_val = acc_w[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
				: {1'b0, {(ACC_BITS-1){1'b1}}};
		end else begin
			acc_val = acc_w[ACC_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			sat_q       <= 1'b0;
			seen_q      <= 1'b0;
			sum_q[0]    <= '0;
			sum_q[1]    <= '0;
			sum_q[2]    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						cur_q <= pop_data;
						sat_q <= 1'b0;
						r2_q  <= '0;
						idx_q <= '0;
						if (pop_data.far) begin
							state_q <= ST_DONE;
						end else begin
							mul_a_q     <= 64'(pop_data.mag_x);
							mul_b_q     <= 64'(pop_data.mag_x);
							mul_start_q <= 1'b1;
							state_q     <= ST_SQ;
						end
					end
				end
				ST_SQ: begin
					if (mul_done) begin
						r2_q <= r2_next;
						if (idx_q == 2'd2) begin
							if ((r2_next[65:64] != 2'b00) || (r2_next == '0)) begin
								state_q <= ST_DONE;
							end else begin
								mul_a_q     <= 64'(cur_q.dsum);
								mul_b_q     <= 64'(cur_q.dsum);
								mul_start_q <= 1'b1;
								state_q     <= ST_DSQ;
							end
						end else begin
							idx_q       <= idx_q + 1'b1;
							mul_a_q     <= 64'(mag_next);
							mul_b_q     <= 64'(mag_next);
							mul_start_q <= 1'b1;
						end
					end
				end
				ST_DSQ: begin
					if (mul_done) begin
						dsq_q       <= mul_p[DSQ_W-1:0];
						mul_a_q     <= 64'(cutoff);
						mul_b_q     <= 64'(mul_p[DSQ_W-1:0]);
						mul_start_q <= 1'b1;
						state_q     <= ST_RHS;
					end
				end
				ST_RHS: begin
					if (mul_done) begin
						if (lhs < mul_p) begin
							div_n_q     <= 128'(dsq_q) << 30;
							div_start_q <= 1'b1;
							state_q     <= ST_DIVS;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DIVS: begin
					if (div_done) begin
						sat_q       <= sat_q | div_sat;
						s_q         <= div_q;
						mul_a_q     <= div_q;
						mul_b_q     <= div_q;
						mul_start_q <= 1'b1;
						state_q     <= ST_Q1;
					end
				end
				ST_Q1: begin
					if (mul_done) begin
						sat_q       <= sat_q | mq_sat;
						mul_a_q     <= mq_val;
						mul_b_q     <= s_q;
						mul_start_q <= 1'b1;
						state_q     <= ST_Q2;
					end
				end
				ST_Q2: begin
					if (mul_done) begin
						sat_q       <= sat_q | mq_sat | twoq_sat;
						attract_q   <= attract;
						mul_a_q     <= mq_val;
						mul_b_q     <= t_val;
						mul_start_q <= 1'b1;
						state_q     <= ST_M;
					end
				end
				ST_M: begin
					if (mul_done) begin
						sat_q       <= sat_q | mq_sat;
						m_q         <= mq_val;
						idx_q       <= '0;
						div_n_q     <= 128'(cur_q.mag_x) << (2 * FRAC_BITS);
						div_start_q <= 1'b1;
						state_q     <= ST_DIVU;
					end
				end
				ST_DIVU: begin
					if (div_done) begin
						sat_q       <= sat_q | div_sat;
						mul_a_q     <= m_q;
						mul_b_q     <= u24;
						mul_start_q <= 1'b1;
						state_q     <= ST_VMUL;
					end
				end
				ST_VMUL: begin
					if (mul_done) begin
						term_q  <= term_val;
						sat_q   <= sat_q | term_sat;
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					sum_q[idx_q] <= acc_val;
					sat_q        <= sat_q | acc_sat;
					if (idx_q == 2'd2) begin
						state_q <= ST_DONE;
					end else begin
						idx_q       <= idx_q + 1'b1;
						div_n_q     <= 128'(mag_next) << (2 * FRAC_BITS);
						div_start_q <= 1'b1;
						state_q     <= ST_DIVU;
					end
				end
				ST_DONE: begin
					if (!cur_q.last) begin
						seen_q  <= seen_all;
						state_q <= ST_IDLE;
					end else if (emit) begin
						out_q.force_x  <= sum_q[0];
						out_q.force_y  <= sum_q[1];
						out_q.force_z  <= sum_q[2];
						out_q.overflow <= seen_all;
						sum_q[0]       <= '0;
						sum_q[1]       <= '0;
						sum_q[2]       <= '0;
						seen_q         <= 1'b0;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/rljpfa_checker.sv =====
// Port checker of the pair force accumulator and its bind to the top level.
`include "repulsive_lj_pair_force_accumulator_macros.svh"

module rljpfa_checker
	import rljpfa_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// A waiting output word holds until it is taken.
	`RLJPFA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))

	// No output word is shown while reset is applied.
	`RLJPFA_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid)

	// The front is empty and ready as soon as reset is released.
	`RLJPFA_ASSERT_ALWAYS(a_ready_after_reset, arst_n && $past(!arst_n) |-> in_ready)

endmodule

bind repulsive_lj_pair_force_accumulator rljpfa_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
